@@ design/pecs_pkg.sv @@
// Shared types and constants for the page entry classifier with statistics.
// Used by the classifier, the counter bank, the result register, the top level and the bench.
// No dependencies.
`default_nettype none

package pecs_pkg;

    localparam int NUM_CTR           = 29;
    localparam int CTR_IDX_W         = 5;
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int CTR_FLAG_BASE     = 6;
    localparam int NUM_FLAGS         = 8;

    // counter indexes
    localparam int CTR_INV_TOP     = 0;
    localparam int CTR_INV_PTR     = 1;
    localparam int CTR_INV_DIR     = 2;
    localparam int CTR_LARGE_PTR   = 3;
    localparam int CTR_LARGE_DIR   = 4;
    localparam int CTR_VALID       = 5;
    localparam int CTR_DZ_PROTO    = 14;
    localparam int CTR_DZ          = 15;
    localparam int CTR_PF_PROTO    = 16;
    localparam int CTR_PF          = 17;
    localparam int CTR_TRANS_PROTO = 18;
    localparam int CTR_VALID_PROTO = 19;
    localparam int CTR_MAPPED      = 20;
    localparam int CTR_MAPPED_PROTO= 21;
    localparam int CTR_UNK_PROTO   = 22;
    localparam int CTR_TRANS       = 23;
    localparam int CTR_PROTO_VAD   = 24;
    localparam int CTR_UNKNOWN     = 25;
    localparam int CTR_EMPTY       = 26;
    localparam int CTR_MODNOWR     = 27;
    localparam int CTR_MODNOWR_PROTO = 28;

    typedef enum logic [1:0] {
        REQ_CLASSIFY = 2'd0,
        REQ_READ     = 2'd1,
        REQ_CLEAR    = 2'd2
    } req_type_t;

    typedef enum logic [3:0] {
        MC_NONE       = 4'd0,
        MC_INVALID    = 4'd1,
        MC_LARGE      = 4'd2,
        MC_EMPTY      = 4'd3,
        MC_VALID      = 4'd4,
        MC_TRANSITION = 4'd5,
        MC_MODNOWRITE = 4'd6,
        MC_MAPPED     = 4'd7,
        MC_VAD        = 4'd8,
        MC_PROTO      = 4'd9,
        MC_DZ         = 4'd10,
        MC_PAGEFILE   = 4'd11,
        MC_UNKNOWN    = 4'd12
    } main_class_t;

    typedef enum logic [2:0] {
        PC_NONE       = 3'd0,
        PC_VALID      = 3'd1,
        PC_TRANSITION = 3'd2,
        PC_MODNOWRITE = 3'd3,
        PC_MAPPED     = 3'd4,
        PC_UNKNOWN    = 3'd5,
        PC_DZ         = 3'd6,
        PC_PAGEFILE   = 3'd7
    } proto_class_t;

    // classifier decision for one request, handed to the counter bank
    typedef struct packed {
        logic                 read;
        logic                 clear;
        main_class_t          main_class;
        proto_class_t         proto_class;
        logic [NUM_FLAGS-1:0] flag_main;
        logic [NUM_FLAGS-1:0] flag_proto;
        logic [NUM_CTR-1:0]   class_bump;
    } pecs_cls_t;

endpackage

`default_nettype wire

@@ design/pecs_req_if.sv @@
// Request channel: valid/ready handshake with the classifier request payload.
// Depends on nothing.
`default_nettype none

interface pecs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  entry_level;
    logic [63:0] entry_value;
    logic [63:0] proto_value;
    logic [11:0] vaddr_low;
    logic [4:0]  counter_index;

    modport source (
        output valid, req_type, entry_level, entry_value, proto_value, vaddr_low,
               counter_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_level, entry_value, proto_value, vaddr_low,
               counter_index,
        output ready
    );
endinterface

`default_nettype wire

@@ design/pecs_rsp_if.sv @@
// Result channel: valid/ready handshake with the classification result payload.
// Depends on nothing.
`default_nettype none

interface pecs_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  main_class;
    logic [2:0]  proto_class;
    logic [7:0]  flag_bits;
    logic [31:0] counter_value;

    modport source (
        output valid, main_class, proto_class, flag_bits, counter_value,
        input  ready
    );

    modport sink (
        input  valid, main_class, proto_class, flag_bits, counter_value,
        output ready
    );
endinterface

`default_nettype wire

@@ design/pecs_classifier.sv @@
// Combinational classification of one request: entry class, prototype class,
// flag bits and the counters to bump. Depends on pecs_pkg.
`default_nettype none

module pecs_classifier (
    input  wire logic [1:0]      req_type,
    input  wire logic [1:0]      entry_level,
    input  wire logic [63:0]     entry_value,
    input  wire logic [63:0]     proto_value,
    input  wire logic [11:0]     vaddr_low,
    output pecs_pkg::pecs_cls_t  cls
);
    import pecs_pkg::*;

    localparam logic [1:0] LVL_LAST = 2'd0;
    localparam logic [1:0] LVL_DIR  = 2'd1;
    localparam logic [1:0] LVL_PTR  = 2'd2;
    localparam logic [1:0] LVL_TOP  = 2'd3;

    function automatic logic is_trans(input logic [63:0] v);
        return (v != 64'd0) && v[11] && !v[10];
    endfunction

    function automatic logic is_pres(input logic [63:0] v);
        return (v != 64'd0) && (v[0] || is_trans(v));
    endfunction

    function automatic logic is_prototype(input logic [63:0] v);
        return (v != 64'd0) && v[10] && !v[11];
    endfunction

    function automatic logic is_pfile(input logic [63:0] v);
        return (v != 64'd0) && !v[10];
    endfunction

    function automatic logic is_subsec(input logic [63:0] v);
        return (v[63:32] != 32'd0) && (v[4:1] == 4'd0) && (v[31:11] == 21'd0);
    endfunction

    // page-aligned offset plus low address bits cannot wrap, so zero means both zero
    function automatic logic pfile_zero(input logic [63:0] v, input logic [11:0] vlow);
        return (v[31:12] == 20'd0) && (vlow == 12'd0);
    endfunction

    function automatic logic [7:0] flags_of(input logic [63:0] v);
        return {v[9], v[6], v[5], ~v[4], ~v[3], ~v[2], v[1], v[8]};
    endfunction

    always_comb
    begin
        cls = '0;
        cls.main_class  = MC_NONE;
        cls.proto_class = PC_NONE;
        case (req_type)
            REQ_READ:
            begin
                cls.read = 1'b1;
            end
            REQ_CLEAR:
            begin
                cls.clear = 1'b1;
            end
            REQ_CLASSIFY:
            begin
                if (entry_level != LVL_LAST)
                begin
                    if (!is_pres(entry_value) && entry_value != 64'd0)
                    begin
                        cls.main_class = MC_INVALID;
                        if (entry_level == LVL_TOP)
                            cls.class_bump[CTR_INV_TOP] = 1'b1;
                        else if (entry_level == LVL_PTR)
                            cls.class_bump[CTR_INV_PTR] = 1'b1;
                        else
                            cls.class_bump[CTR_INV_DIR] = 1'b1;
                    end
                    else if (entry_level != LVL_TOP && entry_value[7])
                    begin
                        cls.main_class = MC_LARGE;
                        if (entry_level == LVL_PTR)
                            cls.class_bump[CTR_LARGE_PTR] = 1'b1;
                        else if (entry_level == LVL_DIR)
                            cls.class_bump[CTR_LARGE_DIR] = 1'b1;
                    end
                end
                else if (entry_value == 64'd0)
                begin
                    cls.main_class = MC_EMPTY;
                    cls.class_bump[CTR_EMPTY] = 1'b1;
                end
                else
                begin
                    cls.flag_main = flags_of(entry_value);
                    if (is_pres(entry_value))
                    begin
                        if (is_trans(entry_value))
                        begin
                            if (entry_value[6])
                            begin
                                cls.main_class = MC_MODNOWRITE;
                                cls.class_bump[CTR_MODNOWR] = 1'b1;
                            end
                            else
                            begin
                                cls.main_class = MC_TRANSITION;
                                cls.class_bump[CTR_TRANS] = 1'b1;
                            end
                        end
                        else
                        begin
                            cls.main_class = MC_VALID;
                            cls.class_bump[CTR_VALID] = 1'b1;
                        end
                    end
                    else if (is_prototype(entry_value))
                    begin
                        if (is_subsec(entry_value))
                        begin
                            cls.main_class = MC_MAPPED;
                            cls.class_bump[CTR_MAPPED] = 1'b1;
                        end
                        else if (entry_value[63:32] == 32'hFFFF_FFFF)
                        begin
                            cls.main_class = MC_VAD;
                            cls.class_bump[CTR_PROTO_VAD] = 1'b1;
                        end
                        else
                        begin
                            // second pass on the prototype entry
                            cls.main_class = MC_PROTO;
                            cls.flag_proto = flags_of(proto_value);
                            if (is_pres(proto_value))
                            begin
                                if (is_trans(proto_value))
                                begin
                                    if (proto_value[6])
                                    begin
                                        cls.proto_class = PC_MODNOWRITE;
                                        cls.class_bump[CTR_MODNOWR_PROTO] = 1'b1;
                                    end
                                    else
                                    begin
                                        cls.proto_class = PC_TRANSITION;
                                        cls.class_bump[CTR_TRANS_PROTO] = 1'b1;
                                    end
                                end
                                else
                                begin
                                    cls.proto_class = PC_VALID;
                                    cls.class_bump[CTR_VALID_PROTO] = 1'b1;
                                end
                            end
                            else if (is_prototype(proto_value))
                            begin
                                if (is_subsec(proto_value))
                                begin
                                    cls.proto_class = PC_MAPPED;
                                    cls.class_bump[CTR_MAPPED_PROTO] = 1'b1;
                                end
                                else
                                begin
                                    cls.proto_class = PC_UNKNOWN;
                                    cls.class_bump[CTR_UNK_PROTO] = 1'b1;
                                end
                            end
                            else if (is_pfile(proto_value))
                            begin
                                if (pfile_zero(proto_value, vaddr_low))
                                begin
                                    cls.proto_class = PC_DZ;
                                    cls.class_bump[CTR_DZ_PROTO] = 1'b1;
                                end
                                else
                                begin
                                    cls.proto_class = PC_PAGEFILE;
                                    cls.class_bump[CTR_PF_PROTO] = 1'b1;
                                end
                            end
                            else
                            begin
                                cls.proto_class = PC_UNKNOWN;
                                cls.class_bump[CTR_UNK_PROTO] = 1'b1;
                            end
                        end
                    end
                    else if (is_pfile(entry_value))
                    begin
                        if (pfile_zero(entry_value, vaddr_low))
                        begin
                            cls.main_class = MC_DZ;
                            cls.class_bump[CTR_DZ] = 1'b1;
                        end
                        else
                        begin
                            cls.main_class = MC_PAGEFILE;
                            cls.class_bump[CTR_PF] = 1'b1;
                        end
                    end
                    else
                    begin
                        cls.main_class = MC_UNKNOWN;
                        cls.class_bump[CTR_UNKNOWN] = 1'b1;
                    end
                end
            end
            default:
            begin
                cls = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/pecs_counter_bank.sv @@
// Bank of saturating statistic counters with clear-all and one read port.
// Depends on pecs_pkg.
`default_nettype none

module pecs_counter_bank #(
    parameter int COUNTER_WIDTH = pecs_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          upd_en,
    input  wire pecs_pkg::pecs_cls_t           cls,
    input  wire logic [pecs_pkg::CTR_IDX_W-1:0] rd_idx,
    output logic [31:0]                        rd_value
);
    import pecs_pkg::*;

    logic [COUNTER_WIDTH-1:0] ctr_reg  [NUM_CTR];
    logic [COUNTER_WIDTH-1:0] ctr_next [NUM_CTR];

    // a flag counter can take one from the entry and one from its prototype
    for (genvar i = 0; i < NUM_CTR; i++)
    begin : g_ctr
        logic [1:0]             inc;
        logic [COUNTER_WIDTH:0] sum;

        if (i >= CTR_FLAG_BASE && i < CTR_FLAG_BASE + NUM_FLAGS)
        begin : g_flag
            assign inc = {1'b0, cls.class_bump[i]}
                       + {1'b0, cls.flag_main[i - CTR_FLAG_BASE]}
                       + {1'b0, cls.flag_proto[i - CTR_FLAG_BASE]};
        end
        else
        begin : g_class
            assign inc = {1'b0, cls.class_bump[i]};
        end

        assign sum = {1'b0, ctr_reg[i]} + (COUNTER_WIDTH + 1)'(inc);

        always_comb
        begin
            if (cls.clear)
                ctr_next[i] = '0;
            else if (sum[COUNTER_WIDTH])
                ctr_next[i] = '1;
            else
                ctr_next[i] = sum[COUNTER_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTR; i++)
                ctr_reg[i] <= '0;
        end
        else if (upd_en)
        begin
            for (int i = 0; i < NUM_CTR; i++)
                ctr_reg[i] <= ctr_next[i];
        end
    end

    assign rd_value = (rd_idx < CTR_IDX_W'(NUM_CTR)) ? 32'(ctr_reg[rd_idx]) : 32'd0;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en && cls.clear |=> ctr_reg[CTR_VALID] == '0 && ctr_reg[CTR_FLAG_BASE] == '0)
        else $error("counters not cleared");

    a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !(upd_en && cls.clear) |=> ctr_reg[CTR_FLAG_BASE] >= $past(ctr_reg[CTR_FLAG_BASE]))
        else $error("counter went backwards without a clear");

    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd_en |=> $stable(ctr_reg[CTR_EMPTY]))
        else $error("counter changed without an update");

endmodule

`default_nettype wire

@@ design/pecs_result_reg.sv @@
// Result register stage: holds one finished result until the sink takes it.
// Depends on pecs_pkg.
`default_nettype none

module pecs_result_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          load_valid,
    input  wire pecs_pkg::pecs_cls_t cls,
    input  wire logic [31:0]   rd_value,
    output logic               advance,
    pecs_rsp_if.source         rsp
);
    import pecs_pkg::*;

    logic        valid_reg;
    logic [3:0]  main_class_reg;
    logic [2:0]  proto_class_reg;
    logic [7:0]  flag_bits_reg;
    logic [31:0] counter_value_reg;

    assign advance = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load && load_valid)
        begin
            main_class_reg    <= cls.main_class;
            proto_class_reg   <= cls.proto_class;
            flag_bits_reg     <= cls.flag_main;
            counter_value_reg <= cls.read ? rd_value : 32'd0;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.main_class    = main_class_reg;
    assign rsp.proto_class   = proto_class_reg;
    assign rsp.flag_bits     = flag_bits_reg;
    assign rsp.counter_value = counter_value_reg;

    a_proto_only: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && main_class_reg != MC_PROTO |-> proto_class_reg == PC_NONE)
        else $error("prototype class without prototype entry");

    a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && counter_value_reg != 32'd0 |-> main_class_reg == MC_NONE
            && flag_bits_reg == 8'd0)
        else $error("counter value on a classify result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !rsp.ready |=> valid_reg && $stable(main_class_reg)
            && $stable(counter_value_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ design/page_entry_classifier_stats.sv @@
// Page entry classifier with statistic counters.
//
// Requests arrive on req (valid/ready). Each carries a request type: classify
// an entry, read one counter, or clear all counters. Every request gives
// exactly one result on rsp (valid/ready): main class, prototype class, flag
// bits of the main entry and, for a read, the low 32 bits of the counter.
//
// A request accepted on req is held in the input register and classified from
// there; when the result register takes it, the counters update and the result
// is loaded, valid on rsp from then on. Throughput is one request per cycle
// while rsp is not stalled; the counter bank updates in the same cycle as the
// result register loads, so a read sees every earlier request.
//
// A stalled rsp holds its result; one further request waits in the input
// register and req.ready drops only when both stages are full.
// Reset clears both stage valids and all 29 counters at once; a clear request
// zeroes them all together. Counters saturate at their maximum.
`default_nettype none

module page_entry_classifier_stats #(
    parameter int COUNTER_WIDTH = pecs_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pecs_req_if.sink   req,
    pecs_rsp_if.source rsp
);
    import pecs_pkg::*;

    logic        s1_valid_reg;
    logic [1:0]  s1_req_type_reg;
    logic [1:0]  s1_level_reg;
    logic [63:0] s1_entry_reg;
    logic [63:0] s1_proto_reg;
    logic [11:0] s1_vlow_reg;
    logic [4:0]  s1_idx_reg;

    logic        s1_adv;
    pecs_cls_t   cls;
    logic [31:0] rd_value;

    assign req.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_req_type_reg <= req.req_type;
            s1_level_reg    <= req.entry_level;
            s1_entry_reg    <= req.entry_value;
            s1_proto_reg    <= req.proto_value;
            s1_vlow_reg     <= req.vaddr_low;
            s1_idx_reg      <= req.counter_index;
        end
    end

    pecs_classifier u_classifier (
        .req_type    (s1_req_type_reg),
        .entry_level (s1_level_reg),
        .entry_value (s1_entry_reg),
        .proto_value (s1_proto_reg),
        .vaddr_low   (s1_vlow_reg),
        .cls         (cls)
    );

    pecs_counter_bank #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (s1_valid_reg && s1_adv),
        .cls      (cls),
        .rd_idx   (s1_idx_reg),
        .rd_value (rd_value)
    );

    pecs_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_adv),
        .load_valid (s1_valid_reg),
        .cls        (cls),
        .rd_value   (rd_value),
        .advance    (s1_adv),
        .rsp        (rsp)
    );

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_entry_reg))
        else $error("input stage dropped a stalled request");

    a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(cls.class_bump))
        else $error("more than one class counter bumped");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("request refused with result stage empty");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for page_entry_classifier_stats: classify, counter read and clear requests.
// Expected results come from a shadow classifier and counter bank kept here in step with accepts.
// Depends on pecs_pkg, pecs_req_if, pecs_rsp_if and the top level.

module testbench;
    import pecs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CTR_W = COUNTER_WIDTH_DEF;
    localparam logic [63:0] CTR_MAX = {64{1'b1}} >> (64 - CTR_W);

    // walk levels
    localparam logic [1:0] LVL_PTE   = 2'd0;
    localparam logic [1:0] LVL_DIR   = 2'd1;
    localparam logic [1:0] LVL_PTR   = 2'd2;
    localparam logic [1:0] LVL_TOP   = 2'd3;
    // request code the block must ignore
    localparam logic [1:0] REQ_BOGUS = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  level;
        logic [63:0] entry;
        logic [63:0] proto;
        logic [11:0] vlow;
        logic [4:0]  ctr_idx;
    } page_req_t;

    typedef struct {
        main_class_t  mc;
        proto_class_t pc;
        logic [7:0]   flags;
        logic [31:0]  cval;
    } page_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pecs_req_if req_if ();
    pecs_rsp_if rsp_if ();

    page_entry_classifier_stats u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    logic [63:0]  ctr_shadow [NUM_CTR];
    page_result_t expected_results [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left = 0;

    // ---------------- shadow classifier ----------------

    function automatic bit is_transition(logic [63:0] v);
        return v != 0 && v[11] && !v[10];
    endfunction

    function automatic bit is_present(logic [63:0] v);
        return v != 0 && (v[0] || is_transition(v));
    endfunction

    function automatic bit is_prototype(logic [63:0] v);
        return v != 0 && v[10] && !v[11];
    endfunction

    function automatic bit is_pagefile(logic [63:0] v);
        return v != 0 && !v[10];
    endfunction

    function automatic bit is_subsection(logic [63:0] v);
        return v[63:32] != 0 && v[4:1] == 0 && v[31:11] == 0;
    endfunction

    // offset plus low address bits is zero only when both are
    function automatic bit pagefile_zero(logic [63:0] v, logic [11:0] vlow);
        return v[31:12] == 0 && vlow == 0;
    endfunction

    function automatic void bump_ctr(int i);
        if (ctr_shadow[i] != CTR_MAX)
            ctr_shadow[i]++;
    endfunction

    function automatic logic [7:0] count_flags(logic [63:0] v);
        logic [7:0] f;
        f = {v[9], v[6], v[5], !v[4], !v[3], !v[2], v[1], v[8]};
        for (int i = 0; i < NUM_FLAGS; i++)
            if (f[i])
                bump_ctr(CTR_FLAG_BASE + i);
        return f;
    endfunction

    function automatic proto_class_t classify_proto(logic [63:0] p, logic [11:0] vlow);
        void'(count_flags(p));
        if (is_present(p)) begin
            if (is_transition(p)) begin
                if (p[6]) begin
                    bump_ctr(CTR_MODNOWR_PROTO);
                    return PC_MODNOWRITE;
                end
                bump_ctr(CTR_TRANS_PROTO);
                return PC_TRANSITION;
            end
            bump_ctr(CTR_VALID_PROTO);
            return PC_VALID;
        end
        if (is_prototype(p)) begin
            if (is_subsection(p)) begin
                bump_ctr(CTR_MAPPED_PROTO);
                return PC_MAPPED;
            end
            bump_ctr(CTR_UNK_PROTO);
            return PC_UNKNOWN;
        end
        if (is_pagefile(p)) begin
            if (pagefile_zero(p, vlow)) begin
                bump_ctr(CTR_DZ_PROTO);
                return PC_DZ;
            end
            bump_ctr(CTR_PF_PROTO);
            return PC_PAGEFILE;
        end
        bump_ctr(CTR_UNK_PROTO);
        return PC_UNKNOWN;
    endfunction

    function automatic page_result_t predict_and_count(page_req_t r);
        page_result_t res;
        logic [63:0]  e;
        res.mc    = MC_NONE;
        res.pc    = PC_NONE;
        res.flags = '0;
        res.cval  = '0;
        e = r.entry;
        if (r.op == REQ_READ) begin
            if (r.ctr_idx < NUM_CTR)
                res.cval = ctr_shadow[r.ctr_idx][31:0];
        end else if (r.op == REQ_CLEAR) begin
            foreach (ctr_shadow[i])
                ctr_shadow[i] = '0;
        end else if (r.op == REQ_CLASSIFY) begin
            if (r.level != LVL_PTE) begin
                if (!is_present(e) && e != 0) begin
                    res.mc = MC_INVALID;
                    bump_ctr(r.level == LVL_TOP ? CTR_INV_TOP :
                             r.level == LVL_PTR ? CTR_INV_PTR : CTR_INV_DIR);
                end else if (r.level != LVL_TOP && e[7]) begin
                    res.mc = MC_LARGE;
                    bump_ctr(r.level == LVL_PTR ? CTR_LARGE_PTR : CTR_LARGE_DIR);
                end
            end else if (e == 0) begin
                res.mc = MC_EMPTY;
                bump_ctr(CTR_EMPTY);
            end else begin
                res.flags = count_flags(e);
                if (is_present(e)) begin
                    if (!is_transition(e)) begin
                        res.mc = MC_VALID;
                        bump_ctr(CTR_VALID);
                    end else if (e[6]) begin
                        res.mc = MC_MODNOWRITE;
                        bump_ctr(CTR_MODNOWR);
                    end else begin
                        res.mc = MC_TRANSITION;
                        bump_ctr(CTR_TRANS);
                    end
                end else if (is_prototype(e)) begin
                    if (is_subsection(e)) begin
                        res.mc = MC_MAPPED;
                        bump_ctr(CTR_MAPPED);
                    end else if (e[63:32] == 32'hFFFF_FFFF) begin
                        res.mc = MC_VAD;
                        bump_ctr(CTR_PROTO_VAD);
                    end else begin
                        res.mc = MC_PROTO;
                        res.pc = classify_proto(r.proto, r.vlow);
                    end
                end else if (is_pagefile(e)) begin
                    if (pagefile_zero(e, r.vlow)) begin
                        res.mc = MC_DZ;
                        bump_ctr(CTR_DZ);
                    end else begin
                        res.mc = MC_PAGEFILE;
                        bump_ctr(CTR_PF);
                    end
                end else begin
                    res.mc = MC_UNKNOWN;
                    bump_ctr(CTR_UNKNOWN);
                end
            end
        end
        return res;
    endfunction

    // ---------------- result checking ----------------

    function automatic void report(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        fail_count++;
    endfunction

    always @(posedge clk) begin
        page_result_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual main_class %0d",
                         $time, rsp_if.main_class);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (rsp_if.main_class !== want.mc)
                    report("main_class", want.mc, rsp_if.main_class);
                if (rsp_if.proto_class !== want.pc)
                    report("proto_class", want.pc, rsp_if.proto_class);
                if (rsp_if.flag_bits !== want.flags)
                    report("flag_bits", want.flags, rsp_if.flag_bits);
                if (rsp_if.counter_value !== want.cval)
                    report("counter_value", want.cval, rsp_if.counter_value);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("page_entry_classifier_stats regression: fail");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is armed
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ---------------- request side ----------------

    function automatic page_req_t make_req(logic [1:0] op, logic [1:0] level,
                                           logic [63:0] entry, logic [63:0] proto,
                                           logic [11:0] vlow, logic [4:0] ctr_idx);
        page_req_t r;
        r.op      = op;
        r.level   = level;
        r.entry   = entry;
        r.proto   = proto;
        r.vlow    = vlow;
        r.ctr_idx = ctr_idx;
        return r;
    endfunction

    task automatic push_request(input page_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= r.op;
        req_if.entry_level   <= r.level;
        req_if.entry_value   <= r.entry;
        req_if.proto_value   <= r.proto;
        req_if.vaddr_low     <= r.vlow;
        req_if.counter_index <= r.ctr_idx;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        expected_results.push_back(predict_and_count(r));
    endtask

    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // entry biased towards each class, other bits random
    function automatic logic [63:0] random_entry();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: ;
            2: v[0] = 1'b1;
            3: v[11:10] = 2'b10;
            4: begin
                v[31:11] = '0;
                v[4:1]   = '0;
                v[10]    = 1'b1;
                v[0]     = 1'b0;
                if (v[63:32] == 0)
                    v[32] = 1'b1;
            end
            5: begin
                v[63:32] = '1;
                v[11:10] = 2'b01;
                v[0]     = 1'b0;
            end
            6: begin
                v[11:10] = 2'b01;
                v[0]     = 1'b0;
                if ($urandom_range(0, 1))
                    v[63:32] = '0;
            end
            7: begin
                v[11:10] = 2'b00;
                v[0]     = 1'b0;
            end
            8: begin
                v[31:12] = '0;
                v[11:10] = 2'b00;
                v[0]     = 1'b0;
            end
            default: begin
                v[11:10] = 2'b11;
                v[0]     = 1'b0;
            end
        endcase
        return v;
    endfunction

    function automatic page_req_t random_req();
        page_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        r = make_req(REQ_CLASSIFY, 2'($urandom_range(0, 3)), random_entry(), random_entry(),
                     $urandom_range(0, 3) == 0 ? 12'h0 : 12'($urandom_range(0, 4095)),
                     5'($urandom_range(0, 31)));
        // most requests classify a last-level entry, the rest spread over the upper levels
        if ($urandom_range(0, 99) < 60)
            r.level = LVL_PTE;
        if (pick >= 97)
            r.op = REQ_BOGUS;
        else if (pick >= 94)
            r.op = REQ_CLEAR;
        else if (pick >= 82)
            r.op = REQ_READ;
        return r;
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed_classes();
        // upper levels: invalid, large, top never large, plain pointer
        push_request(make_req(REQ_CLASSIFY, LVL_TOP, 64'h2, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_TOP, 64'h81, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTR, 64'h81, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_DIR, '1, '1, 12'hFFF, 5'd31));
        push_request(make_req(REQ_CLASSIFY, LVL_PTR, 64'h800, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTR, 64'h80, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_DIR, 64'h80, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_DIR, 64'h0, 64'h0, 12'h0, 5'd0));
        // last level
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h0, '1, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, '1, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h1, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h800, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h840, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h1_0000_0400, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'hFFFF_FFFF_0000_0402, 64'h0,
                              12'h0, 5'd0));
        // prototype entry, every prototype class
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h1, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h800, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h840, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h1_0000_0400, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h400, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h2, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h2, 12'h5, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h400, 64'hC00, 12'h0, 5'd0));
        // demand zero, pagefile, unknown, ignored request code
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h2, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'h2, 64'h0, 12'hFFF, 5'd0));
        push_request(make_req(REQ_CLASSIFY, LVL_PTE, 64'hC00, 64'h0, 12'h0, 5'd0));
        push_request(make_req(REQ_BOGUS, LVL_TOP, '1, '1, 12'hFFF, 5'd31));
    endtask

    // every index including the unused ones, then clear and look again
    task automatic test_counter_readback();
        pause_until_drained();
        for (int i = 0; i < 32; i++)
            push_request(make_req(REQ_READ, 2'($urandom), {$urandom, $urandom},
                                  {$urandom, $urandom}, 12'($urandom), 5'(i)));
        push_request(make_req(REQ_CLEAR, LVL_PTE, 64'h0, 64'h0, 12'h0, 5'd0));
        for (int i = 0; i < 4; i++)
            push_request(make_req(REQ_READ, LVL_PTE, 64'h0, 64'h0, 12'h0,
                                  5'($urandom_range(0, 31))));
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++)
            push_request(random_req());
    endtask

    // result side held off long enough for the block to fill and refuse requests
    task automatic test_backpressure();
        pause_until_drained();
        hold_left = 300;
        for (int i = 0; i < 40; i++)
            push_request(random_req());
        pause_until_drained();
    endtask

    initial begin
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_CLASSIFY;
        req_if.entry_level   = LVL_PTE;
        req_if.entry_value   = '0;
        req_if.proto_value   = '0;
        req_if.vaddr_low     = '0;
        req_if.counter_index = '0;
        foreach (ctr_shadow[i])
            ctr_shadow[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_classes();
        test_counter_readback();

        send_idle_pct = 30;
        recv_idle_pct = 53;
        test_random_traffic(600);
        test_counter_readback();

        send_idle_pct = 53;
        recv_idle_pct = 30;
        test_random_traffic(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_traffic(560);
        test_counter_readback();

        pause_until_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("page_entry_classifier_stats regression: pass");
        else
            $display("page_entry_classifier_stats regression: fail");
        $finish;
    end

endmodule
